/* rtl/iecdev_pkg.sv */
// ----------------------------------------------------------------------------
// Serial-bus disk device package
// Shared constants for the device front end: bus commands, write phases,
// request kinds, read status codes and port widths.
// ----------------------------------------------------------------------------
package iecdev_pkg;

	localparam int DEF_CHANNEL_COUNT = 16;
	localparam int DEF_SECTOR_SIZE   = 256;

	localparam logic [3:0] DEF_DEVICE_UNIT = 4'd8;

	localparam int UNIT_W   = 4;
	localparam int CH_SEL_W = 4;
	localparam int BYTE_W   = 8;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;
	localparam int PHASE_W  = 2;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - 2;

	localparam logic [7:0] CMD_LISTEN     = 8'h20;
	localparam logic [7:0] CMD_UNLISTEN   = 8'h3f;
	localparam logic [7:0] CMD_TALK       = 8'h40;
	localparam logic [7:0] CMD_UNTALK     = 8'h5f;
	localparam logic [7:0] CMD_SECONDARY  = 8'h60;
	localparam logic [7:0] CMD_CLOSE      = 8'he0;
	localparam logic [7:0] CMD_OPEN       = 8'hf0;
	localparam logic [7:0] CMD_GROUP_MASK = 8'hf0;

	localparam logic [7:0] NAME_DIRECT = 8'h23;
	localparam logic [3:0] CH_COMMAND  = 4'hf;

	localparam logic [1:0] PHASE_NONE = 2'd0;
	localparam logic [1:0] PHASE_OPEN = 2'd1;
	localparam logic [1:0] PHASE_DATA = 2'd2;

	localparam logic [1:0] REQ_ATTN = 2'd0;
	localparam logic [1:0] REQ_SEND = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	localparam logic [1:0] STAT_NONE = 2'd0;
	localparam logic [1:0] STAT_BYTE = 2'd1;
	localparam logic [1:0] STAT_END  = 2'd2;
	localparam logic [1:0] STAT_BAD  = 2'd3;

endpackage

/* rtl/iec_bus_device_direct_channels.sv */
// ----------------------------------------------------------------------------
// Serial-bus disk device, direct-access channels
// Follows bus attention commands for its unit, keeps per-channel state and
// serves direct-access channel buffers held in a shared RAM.
// ----------------------------------------------------------------------------
// Each request is taken only while the sequencer is idle and returns exactly
// one result. Attention bytes, sent bytes and refused reads pass through the
// execute and done states before the result is registered at the output; a
// buffer read also passes through a read state for the registered RAM read.
// An OPEN that is ended by UNLISTEN with a name beginning with '#' sweeps the
// channel buffer to zero through the single RAM write port, one byte a cycle,
// in a clear state before the done state. A result that is not taken holds
// the sequencer until it is. A single incrementer serves the sweep counter
// and the buffer positions.
module iec_bus_device_direct_channels
	import iecdev_pkg::*;
#(
	parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT,
	parameter int SECTOR_SIZE   = DEF_SECTOR_SIZE
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [UNIT_W-1:0]      cfg_data,     // device_unit
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,      // bus_byte
	input  logic [REQ_W-1:0]       s_tuser,      // req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,      // read_byte, now_listening, now_talking, pad
	output logic [STAT_W-1:0]      m_tuser       // read_status
);

	localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int POS_W  = $clog2(SECTOR_SIZE);
	localparam int ADDR_W = CH_W + POS_W;
	localparam int DEPTH  = 2 ** ADDR_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CLEAR = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [REQ_W-1:0]    type_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [UNIT_W-1:0]   unit_q;
	logic                addr_q;
	logic                listen_q;
	logic                talk_q;
	logic [CH_SEL_W-1:0] chsel_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [BYTE_W-1:0]   name_q;
	logic                named_q;
	logic [CHANNEL_COUNT-1:0] open_q;
	logic [CHANNEL_COUNT-1:0] direct_q;
	logic [POS_W-1:0]    pos_q [CHANNEL_COUNT];
	logic [POS_W-1:0]    clr_q;
	logic [STAT_W-1:0]   rstat_q;
	logic [BYTE_W-1:0]   rbyte_q;
	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	logic [CH_W-1:0]     ch_idx;
	logic                ch_ok;
	logic [POS_W-1:0]    pos_cur;
	logic [POS_W-1:0]    inc_a;
	logic [POS_W:0]      inc_y;
	logic                inc_wrap;
	logic                name_direct;
	logic                send_direct;
	logic                read_ok;
	logic                out_load;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [BYTE_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	assign ch_idx  = chsel_q[CH_W-1:0];
	assign ch_ok   = {1'b0, chsel_q} < (CH_SEL_W + 1)'(CHANNEL_COUNT);
	assign pos_cur = pos_q[ch_idx];

	// The one incrementer, shared by the clearing sweep and the buffer position.
	assign inc_a    = (state_q == S_CLEAR) ? clr_q : pos_cur;
	assign inc_y    = {1'b0, inc_a} + (POS_W + 1)'(1);
	assign inc_wrap = inc_y >= (POS_W + 1)'(SECTOR_SIZE);

	assign name_direct = (chsel_q != CH_COMMAND) && named_q && (name_q == NAME_DIRECT);
	assign send_direct = addr_q && listen_q && (phase_q == PHASE_DATA) && ch_ok
		&& direct_q[ch_idx];
	assign read_ok     = addr_q && talk_q && ch_ok && open_q[ch_idx] && direct_q[ch_idx];

	assign ram_we    = (state_q == S_CLEAR)
		|| ((state_q == S_EXEC) && (type_q == REQ_SEND) && send_direct);
	assign ram_waddr = (state_q == S_CLEAR) ? {ch_idx, clr_q} : {ch_idx, pos_cur};
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : byte_q;
	assign ram_raddr = {ch_idx, pos_cur};

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	iecdev_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			type_q     <= REQ_ATTN;
			byte_q     <= '0;
			unit_q     <= DEF_DEVICE_UNIT;
			addr_q     <= 1'b0;
			listen_q   <= 1'b0;
			talk_q     <= 1'b0;
			chsel_q    <= '0;
			phase_q    <= PHASE_NONE;
			name_q     <= '0;
			named_q    <= 1'b0;
			open_q     <= '0;
			direct_q   <= '0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				pos_q[i] <= '0;
			end
			clr_q      <= '0;
			rstat_q    <= STAT_NONE;
			rbyte_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unit_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						type_q  <= s_tuser;
						byte_q  <= s_tdata;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rstat_q <= STAT_NONE;
					rbyte_q <= '0;
					state_q <= S_DONE;
					case (type_q)
						REQ_ATTN: begin
							if (byte_q == CMD_UNLISTEN) begin
								if (addr_q && listen_q) begin
									if ((phase_q == PHASE_OPEN) && ch_ok) begin
										open_q[ch_idx]   <= 1'b1;
										direct_q[ch_idx] <= name_direct;
										pos_q[ch_idx]    <= name_direct ? POS_W'(1) : '0;
										if (name_direct) begin
											clr_q   <= '0;
											state_q <= S_CLEAR;
										end
									end
									name_q  <= '0;
									named_q <= 1'b0;
									phase_q <= PHASE_NONE;
								end
								listen_q <= 1'b0;
								addr_q   <= 1'b0;
							end else if (byte_q == CMD_UNTALK) begin
								talk_q <= 1'b0;
								addr_q <= 1'b0;
							end else begin
								case (byte_q & CMD_GROUP_MASK)
									CMD_LISTEN: begin
										addr_q   <= byte_q[3:0] == unit_q;
										listen_q <= byte_q[3:0] == unit_q;
										talk_q   <= 1'b0;
										chsel_q  <= '0;
										phase_q  <= PHASE_NONE;
										name_q   <= '0;
										named_q  <= 1'b0;
									end
									CMD_TALK: begin
										addr_q   <= byte_q[3:0] == unit_q;
										talk_q   <= byte_q[3:0] == unit_q;
										listen_q <= 1'b0;
										chsel_q  <= '0;
									end
									CMD_OPEN: begin
										if (addr_q && listen_q) begin
											chsel_q <= byte_q[3:0];
											phase_q <= PHASE_OPEN;
											name_q  <= '0;
											named_q <= 1'b0;
										end
									end
									CMD_CLOSE: begin
										if (addr_q && listen_q
											&& ({1'b0, byte_q[3:0]}
											< (CH_SEL_W + 1)'(CHANNEL_COUNT))) begin
											open_q[byte_q[CH_W-1:0]]   <= 1'b0;
											direct_q[byte_q[CH_W-1:0]] <= 1'b0;
											pos_q[byte_q[CH_W-1:0]]    <= '0;
										end
									end
									CMD_SECONDARY: begin
										if (addr_q) begin
											chsel_q <= byte_q[3:0];
											if (listen_q) begin
												phase_q <= PHASE_DATA;
												name_q  <= '0;
												named_q <= 1'b0;
											end
										end
									end
									default: begin
									end
								endcase
							end
						end
						REQ_SEND: begin
							if (addr_q && listen_q && (phase_q != PHASE_NONE)) begin
								if (send_direct) begin
									pos_q[ch_idx] <= inc_wrap ? '0 : inc_y[POS_W-1:0];
								end else if (!named_q) begin
									name_q  <= byte_q;
									named_q <= 1'b1;
								end
							end
						end
						REQ_READ: begin
							if (read_ok) begin
								pos_q[ch_idx] <= inc_wrap ? POS_W'(1) : inc_y[POS_W-1:0];
								rstat_q       <= inc_wrap ? STAT_END : STAT_BYTE;
								state_q       <= S_READ;
							end
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					rbyte_q <= ram_rdata;
					state_q <= S_DONE;
				end
				S_CLEAR: begin
					clr_q <= inc_y[POS_W-1:0];
					if (inc_wrap) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {OUT_PAD_W'(0), addr_q && talk_q, addr_q && listen_q, rbyte_q};
			m_tuser_q <= rstat_q;
		end
	end

endmodule

/* rtl/iecdev_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iecdev_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/iecdev_chk.sv */
// ----------------------------------------------------------------------------
// Serial-bus disk device port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module iecdev_chk
	import iecdev_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [STAT_W-1:0]      m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result withdrawn before it was taken.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second request was taken while one was in progress.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != STAT_BAD)
		else $error("Read status carries an undefined code.");

	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_NONE) |-> m_tdata[BYTE_W-1:0] == '0)
		else $error("A result without data carries a non-zero byte.");

	a_role_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[BYTE_W] && m_tdata[BYTE_W+1]))
		else $error("Device reports listening and talking at once.");

endmodule

bind iec_bus_device_direct_channels iecdev_chk u_iecdev_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial-bus disk device testbench
// Drives attention, send and read requests into the device front end and
// checks each response against a given result or a cycle-free predictor of
// the device: unit addressing, listen and talk state, the write phase, channel
// opening and closing, and the direct-access channel buffers with positions.
// ----------------------------------------------------------------------------
module tb;
	import iecdev_pkg::*;

	localparam int            WATCHDOG_LIMIT = 5000;
	localparam int            DRAIN_CYCLES   = 300;
	localparam logic [1:0]    REQ_UNUSED     = 2'd3;
	localparam logic [7:0]    HOME_UNIT      = {4'h0, DEF_DEVICE_UNIT};
	localparam logic [7:0]    DIR_CH         = 8'd2;

	typedef struct packed {
		logic [7:0]        rbyte;
		logic [STAT_W-1:0] status;
		logic              lis;
		logic              tlk;
	} dev_result_t;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		logic [7:0]       b;
		logic             given;
		dev_result_t      resp;
	} bus_step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [UNIT_W-1:0]      cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [REQ_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]      m_tuser;

	// Predicted device state.
	logic [3:0] dev_unit;
	logic       addressed, listening, talking;
	logic [3:0] sel_chan;
	logic [1:0] wr_phase;
	logic [7:0] name_byte;
	logic       name_got;
	logic       chan_open [16];
	logic       chan_direct [16];
	logic [7:0] chan_pos [16];
	logic [7:0] chan_buf [16][256];

	dev_result_t awaited_resp[$];
	bus_step_t   plan[$];
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          sent_items = 0;

	iec_bus_device_direct_channels dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void shut_chan(input logic [3:0] c);
		begin
			chan_open[c] = 1'b0;
			chan_direct[c] = 1'b0;
			chan_pos[c] = 8'd0;
			for (int k = 0; k < 256; k++)
				chan_buf[c][k] = 8'd0;
		end
	endfunction

	function automatic dev_result_t predict_bus_event(input logic [1:0] kind,
			input logic [7:0] b);
		dev_result_t r;
		logic [3:0]  ch;
		begin
			r = '0;
			ch = sel_chan;
			case (kind)
			REQ_ATTN: begin
				if (b == CMD_UNLISTEN) begin
					if (addressed && listening) begin
						if (wr_phase == PHASE_OPEN) begin
							shut_chan(ch);
							chan_open[ch] = 1'b1;
							if (ch != CH_COMMAND && name_got && name_byte == NAME_DIRECT) begin
								chan_direct[ch] = 1'b1;
								chan_pos[ch] = 8'd1;
							end
						end
						name_byte = 8'd0;
						name_got = 1'b0;
						wr_phase = PHASE_NONE;
					end
					listening = 1'b0;
					addressed = 1'b0;
				end else if (b == CMD_UNTALK) begin
					talking = 1'b0;
					addressed = 1'b0;
				end else begin
					case (b & CMD_GROUP_MASK)
					CMD_LISTEN: begin
						addressed = (b[3:0] == dev_unit);
						listening = addressed;
						talking = 1'b0;
						sel_chan = 4'd0;
						wr_phase = PHASE_NONE;
						name_byte = 8'd0;
						name_got = 1'b0;
					end
					CMD_TALK: begin
						addressed = (b[3:0] == dev_unit);
						talking = addressed;
						listening = 1'b0;
						sel_chan = 4'd0;
					end
					CMD_OPEN: begin
						if (addressed && listening) begin
							sel_chan = b[3:0];
							wr_phase = PHASE_OPEN;
							name_byte = 8'd0;
							name_got = 1'b0;
						end
					end
					CMD_CLOSE: begin
						if (addressed && listening)
							shut_chan(b[3:0]);
					end
					CMD_SECONDARY: begin
						if (addressed) begin
							sel_chan = b[3:0];
							if (listening) begin
								wr_phase = PHASE_DATA;
								name_byte = 8'd0;
								name_got = 1'b0;
							end
						end
					end
					default: ;
					endcase
				end
			end
			REQ_SEND: begin
				if (addressed && listening && wr_phase != PHASE_NONE) begin
					if (wr_phase == PHASE_DATA && chan_direct[ch]) begin
						chan_buf[ch][chan_pos[ch]] = b;
						chan_pos[ch] = chan_pos[ch] + 8'd1;
					end else if (!name_got) begin
						name_byte = b;
						name_got = 1'b1;
					end
				end
			end
			REQ_READ: begin
				if (addressed && talking && chan_open[ch] && chan_direct[ch]) begin
					r.rbyte = chan_buf[ch][chan_pos[ch]];
					if (chan_pos[ch] == 8'hff) begin
						chan_pos[ch] = 8'd1;
						r.status = STAT_END;
					end else begin
						chan_pos[ch] = chan_pos[ch] + 8'd1;
						r.status = STAT_BYTE;
					end
				end
			end
			default: ;
			endcase
			r.lis = addressed && listening;
			r.tlk = addressed && talking;
			return r;
		end
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		begin
			$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
			mismatch_count++;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic push_request(input logic [1:0] kind, input logic [7:0] b,
			input logic given, input dev_result_t resp);
		dev_result_t guess;
		begin
			while ($urandom_range(0, 99) < send_idle) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tuser = kind;
			s_tdata = b;
			do @(posedge clk); while (!s_tready);
			guess = predict_bus_event(kind, b);
			awaited_resp.push_back(given ? resp : guess);
			sent_items++;
			@(negedge clk);
		end
	endtask

	task automatic put(input logic [1:0] kind, input logic [7:0] b);
		begin
			push_request(kind, b, 1'b0, '0);
		end
	endtask

	task automatic add_row(input logic [1:0] kind, input logic [7:0] b,
			input logic given, input dev_result_t resp);
		bus_step_t row;
		begin
			row.kind = kind;
			row.b = b;
			row.given = given;
			row.resp = resp;
			plan.push_back(row);
		end
	endtask

	task automatic run_session(input int room);
		int         pick;
		int         n;
		int         r;
		logic [7:0] u;
		logic [7:0] ch;
		begin
			pick = $urandom_range(0, 9);
			u = {4'h0, ($urandom_range(0, 9) == 0) ? 4'($urandom) : dev_unit};
			r = $urandom_range(0, 7);
			ch = {4'h0, (r == 0) ? CH_COMMAND : (r == 1) ? 4'($urandom)
				: 4'($urandom_range(0, 3))};
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(150, 300)
				: $urandom_range(1, 20);
			if (n > room)
				n = room;
			case (pick)
			0, 1: begin
				put(REQ_ATTN, CMD_LISTEN | u);
				put(REQ_ATTN, CMD_OPEN | ch);
				r = $urandom_range(0, 5);
				if (r == 1) begin
					put(REQ_SEND, 8'($urandom));
				end else if (r > 1) begin
					put(REQ_SEND, NAME_DIRECT);
					repeat ($urandom_range(0, 3)) put(REQ_SEND, 8'($urandom));
				end
				if ($urandom_range(0, 9) != 0) put(REQ_ATTN, CMD_UNLISTEN);
			end
			2, 3: begin
				put(REQ_ATTN, CMD_LISTEN | u);
				put(REQ_ATTN, CMD_SECONDARY | ch);
				repeat (n) put(REQ_SEND, 8'($urandom));
				if ($urandom_range(0, 9) != 0) put(REQ_ATTN, CMD_UNLISTEN);
			end
			4, 5, 6: begin
				put(REQ_ATTN, CMD_TALK | u);
				put(REQ_ATTN, CMD_SECONDARY | ch);
				repeat (n) put(REQ_READ, 8'($urandom));
				if ($urandom_range(0, 9) != 0) put(REQ_ATTN, CMD_UNTALK);
			end
			7: begin
				put(REQ_ATTN, CMD_LISTEN | u);
				put(REQ_ATTN, CMD_CLOSE | ch);
				put(REQ_ATTN, CMD_UNLISTEN);
			end
			default: begin
				repeat ($urandom_range(1, 6)) put(2'($urandom), 8'($urandom));
			end
			endcase
		end
	endtask

	// The unit number is only changed once every response has come back.
	task automatic run_phase(input int s_idle, input int r_idle, input logic [3:0] unit,
			input int count);
		begin
			s_tvalid = 1'b0;
			while (awaited_resp.size() != 0) @(negedge clk);
			repeat (8) @(negedge clk);
			cfg_valid = 1'b1;
			cfg_data = unit;
			do @(posedge clk); while (!cfg_ready);
			dev_unit = unit;
			@(negedge clk);
			cfg_valid = 1'b0;
			send_idle = s_idle;
			recv_idle = r_idle;
			sent_items = 0;
			while (sent_items < count) run_session(count - sent_items);
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		dev_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_resp.size() == 0) begin
				flag_mismatch("unexpected response", m_tdata, 0);
			end else begin
				want = awaited_resp.pop_front();
				if (m_tdata[7:0] !== want.rbyte)
					flag_mismatch("read_byte", m_tdata[7:0], want.rbyte);
				if (m_tuser !== want.status)
					flag_mismatch("read_status", m_tuser, want.status);
				if (m_tdata[8] !== want.lis)
					flag_mismatch("now_listening", m_tdata[8], want.lis);
				if (m_tdata[9] !== want.tlk)
					flag_mismatch("now_talking", m_tdata[9], want.tlk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_ATTN;
		m_tready = 1'b0;

		dev_unit = DEF_DEVICE_UNIT;
		addressed = 1'b0;
		listening = 1'b0;
		talking = 1'b0;
		sel_chan = 4'd0;
		wr_phase = PHASE_NONE;
		name_byte = 8'd0;
		name_got = 1'b0;
		for (int c = 0; c < 16; c++)
			shut_chan(4'(c));

		// A read before anything is addressed, then a direct-access channel is
		// opened, filled, read on past the written bytes and closed again.
		add_row(REQ_READ, 8'h00, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b0});
		add_row(REQ_ATTN, CMD_LISTEN | HOME_UNIT, 1'b1, {8'h00, STAT_NONE, 1'b1, 1'b0});
		add_row(REQ_ATTN, CMD_OPEN | DIR_CH, 1'b1, {8'h00, STAT_NONE, 1'b1, 1'b0});
		add_row(REQ_SEND, NAME_DIRECT, 1'b0, '0);
		add_row(REQ_SEND, 8'h41, 1'b0, '0);
		add_row(REQ_ATTN, CMD_UNLISTEN, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b0});
		add_row(REQ_ATTN, CMD_LISTEN | HOME_UNIT, 1'b0, '0);
		add_row(REQ_ATTN, CMD_SECONDARY | DIR_CH, 1'b0, '0);
		add_row(REQ_SEND, 8'hff, 1'b0, '0);
		add_row(REQ_SEND, 8'h00, 1'b0, '0);
		add_row(REQ_ATTN, CMD_UNLISTEN, 1'b0, '0);
		add_row(REQ_ATTN, CMD_TALK | HOME_UNIT, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b1});
		add_row(REQ_ATTN, CMD_SECONDARY | DIR_CH, 1'b0, '0);
		add_row(REQ_READ, 8'h00, 1'b1, {8'h00, STAT_BYTE, 1'b0, 1'b1});
		add_row(REQ_READ, 8'hff, 1'b1, {8'h00, STAT_BYTE, 1'b0, 1'b1});
		add_row(REQ_UNUSED, 8'hff, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b1});
		add_row(REQ_ATTN, CMD_UNTALK, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b0});
		add_row(REQ_ATTN, CMD_UNLISTEN, 1'b0, '0);
		add_row(REQ_ATTN, CMD_LISTEN | 8'h0f, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b0});
		add_row(REQ_ATTN, 8'h38, 1'b0, '0);
		add_row(REQ_ATTN, CMD_LISTEN | HOME_UNIT, 1'b0, '0);
		add_row(REQ_ATTN, CMD_CLOSE | DIR_CH, 1'b0, '0);
		add_row(REQ_ATTN, CMD_UNLISTEN, 1'b0, '0);
		add_row(REQ_ATTN, CMD_TALK | HOME_UNIT, 1'b0, '0);
		add_row(REQ_ATTN, CMD_SECONDARY | DIR_CH, 1'b0, '0);
		add_row(REQ_READ, 8'h00, 1'b1, {8'h00, STAT_NONE, 1'b0, 1'b1});
		add_row(REQ_ATTN, CMD_UNTALK, 1'b0, '0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			push_request(plan[i].kind, plan[i].b, plan[i].given, plan[i].resp);

		run_phase(15, 88, 4'h0, 200);
		run_phase(88, 15, 4'hf, 200);
		run_phase(0, 0, 4'($urandom_range(1, 14)), 200);

		s_tvalid = 1'b0;
		while (awaited_resp.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* iec_bus_device_direct_channels.f */
rtl/iecdev_pkg.sv
rtl/iecdev_ram.sv
rtl/iec_bus_device_direct_channels.sv
rtl/iecdev_chk.sv
bench/tb.sv
